// ===== rtl/core/lrie_pkg.sv =====
// ----------------------------------------------------------------------------
// lrie_pkg: shared definitions for the left-to-right expression evaluator
// Holds the value width, character codes, operator and status codes, and the
// request and response structs between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package lrie_pkg;

    localparam int VALUE_W  = 32;
    localparam int OUT_W    = 32;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CHAR_W-1:0]  t_char;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_SYNTAX  = 2'd1,
        ST_DIVZERO = 2'd2
    } t_status;

    localparam t_char CH_NUL   = 8'h00;
    localparam t_char CH_STAR  = 8'h2A;
    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_SLASH = 8'h2F;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_NINE  = 8'h39;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic idle;
        logic done;
        logic div_zero;
    } t_alu_rsp;

    function automatic logic is_op_char(input t_char c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

    function automatic t_op op_of_char(input t_char c);
        t_op op;
        case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            default:  op = OP_DIV;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/core/lrie_alu.sv =====
// ----------------------------------------------------------------------------
// lrie_alu: iterative arithmetic unit
// One adder serves add, subtract, shift-add multiply, restoring division on
// magnitudes and the sign steps around it, one bit per cycle.
// ----------------------------------------------------------------------------
module lrie_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lrie_pkg::t_alu_req i_req,
    input  lrie_pkg::t_value  i_a,
    input  lrie_pkg::t_value  i_b,
    output lrie_pkg::t_alu_rsp o_rsp,
    output lrie_pkg::t_value  o_result
);
    import lrie_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_ABSA, S_ABSB, S_MUL, S_DIV, S_FIX, S_DONE
    } t_state;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    t_value             r_acc, n_acc;
    t_value             r_q, n_q;
    t_value             r_b, n_b;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic               r_dz, n_dz;

    logic [VALUE_W:0]   w_x, w_y, w_sum;
    logic               w_cin;
    t_value             w_shift;

    // Partial remainder shifted left with the next dividend bit.
    assign w_shift = {r_acc[VALUE_W-2:0], r_q[VALUE_W-1]};

    always_comb begin
        w_x   = '0;
        w_y   = '0;
        w_cin = 1'b0;
        case (r_state)
            S_ADD: begin
                w_x   = {1'b0, r_acc};
                w_y   = (r_op == OP_SUB) ? ~{1'b0, r_b} : {1'b0, r_b};
                w_cin = (r_op == OP_SUB);
            end
            S_ABSA: begin
                w_y   = ~{1'b0, r_q};
                w_cin = 1'b1;
            end
            S_ABSB: begin
                w_y   = ~{1'b0, r_b};
                w_cin = 1'b1;
            end
            S_MUL: begin
                w_x = {1'b0, r_acc};
                w_y = r_q[0] ? {1'b0, r_b} : '0;
            end
            S_DIV: begin
                w_x   = {1'b0, w_shift};
                w_y   = ~{1'b0, r_b};
                w_cin = 1'b1;
            end
            S_FIX: begin
                w_y   = ~{1'b0, r_q};
                w_cin = 1'b1;
            end
            default: begin
                w_x = '0;
            end
        endcase
    end

    assign w_sum = w_x + w_y + (VALUE_W+1)'(w_cin);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_acc   = r_acc;
        n_q     = r_q;
        n_b     = r_b;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_dz    = r_dz;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_dz  = 1'b0;
                    n_cnt = CNT_W'(VALUE_W - 1);
                    n_b   = i_b;
                    case (i_req.op)
                        OP_ADD, OP_SUB: begin
                            n_acc   = i_a;
                            n_state = S_ADD;
                        end
                        OP_MUL: begin
                            n_acc   = '0;
                            n_q     = i_a;
                            n_state = S_MUL;
                        end
                        default: begin
                            n_acc = '0;
                            n_q   = i_a;
                            n_neg = i_a[VALUE_W-1] ^ i_b[VALUE_W-1];
                            if (i_b == '0) begin
                                n_dz    = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_ABSA;
                            end
                        end
                    endcase
                end
            end
            S_ADD: begin
                n_acc   = w_sum[VALUE_W-1:0];
                n_state = S_DONE;
            end
            S_ABSA: begin
                if (r_q[VALUE_W-1]) begin
                    n_q = w_sum[VALUE_W-1:0];
                end
                n_state = S_ABSB;
            end
            S_ABSB: begin
                if (r_b[VALUE_W-1]) begin
                    n_b = w_sum[VALUE_W-1:0];
                end
                n_state = S_DIV;
            end
            S_MUL: begin
                n_acc = w_sum[VALUE_W-1:0];
                n_b   = {r_b[VALUE_W-2:0], 1'b0};
                n_q   = {1'b0, r_q[VALUE_W-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                // A clear sign bit means the trial subtraction did not borrow.
                if (!w_sum[VALUE_W]) begin
                    n_acc = w_sum[VALUE_W-1:0];
                    n_q   = {r_q[VALUE_W-2:0], 1'b1};
                end else begin
                    n_acc = w_shift;
                    n_q   = {r_q[VALUE_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_acc   = r_neg ? w_sum[VALUE_W-1:0] : r_q;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dz    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_dz    <= n_dz;
            r_cnt   <= n_cnt;
        end
        r_op  <= n_op;
        r_acc <= n_acc;
        r_q   <= n_q;
        r_b   <= n_b;
        r_neg <= n_neg;
    end

    assign o_rsp.idle     = (r_state == S_IDLE);
    assign o_rsp.done     = (r_state == S_DONE);
    assign o_rsp.div_zero = (r_state == S_DONE) && r_dz;
    assign o_result       = r_acc;

    // A zero divisor can only be flagged for a division request.
    a_dz_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.div_zero |-> (r_op == OP_DIV))
        else $error("lrie_alu: division-by-zero flag on a non-division operation");

endmodule

// ===== rtl/core/left_to_right_integer_expression_eval_unit.sv =====
// ----------------------------------------------------------------------------
// left_to_right_integer_expression_eval_unit: expression evaluator top level
// Parses an ASCII expression one character per word and evaluates it strictly
// left to right using a shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one ASCII character per word on i_in_char_code.
// Digits build the current number, the characters + - * / apply the pending
// operator, and a NUL word ends the expression. Each NUL produces exactly one
// output word carrying o_out_value and o_out_status (0 ok, 1 syntax error,
// 2 division by zero); no other character produces an output word.
// Digits and errors are taken without the arithmetic unit. An operator or a
// final NUL that applies a pending operator occupies the shared arithmetic
// unit, which runs multiply and divide as one-bit-per-cycle shift-add and
// restoring division loops (a zero divisor ends the division early). The
// input is not ready meanwhile.
// A NUL passes through the emit state to move the result into the output
// register.
// The output register lets the block keep parsing the next expression while a
// result waits; only a second NUL stalls until the receiver takes the first.
// Synchronous active-low reset clears the parser to its start state and drops
// the output valid.
module left_to_right_integer_expression_eval_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [lrie_pkg::CHAR_W-1:0]           i_in_char_code,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [lrie_pkg::OUT_W-1:0]     o_out_value,
    output logic [lrie_pkg::STATUS_W-1:0]         o_out_status
);
    import lrie_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE, T_CALC, T_CALC_END, T_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_START    = 2'd0,
        PH_NUMBER   = 2'd1,
        PH_AFTER_OP = 2'd2
    } t_phase;

    t_state   r_state, n_state;
    t_value   r_accum, n_accum;
    t_value   r_num, n_num;
    t_op      r_pend, n_pend;
    t_phase   r_phase, n_phase;
    t_status  r_err, n_err;
    logic     r_ovalid, n_ovalid;
    t_value   r_ovalue, n_ovalue;
    t_status  r_ostatus, n_ostatus;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    t_value   w_alu_result;

    logic     w_in_acc;
    logic     w_is_digit;
    logic     w_is_op;
    logic     w_is_nul;
    t_value   w_digit;

    assign o_in_ready = (r_state == T_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_is_digit = (i_in_char_code >= CH_ZERO) && (i_in_char_code <= CH_NINE);
    assign w_is_op    = is_op_char(i_in_char_code);
    assign w_is_nul   = (i_in_char_code == CH_NUL);
    // The low nibble of an ASCII digit is its value.
    assign w_digit    = VALUE_W'(i_in_char_code[3:0]);

    lrie_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_accum),
        .i_b      (r_num),
        .o_rsp    (alu_rsp),
        .o_result (w_alu_result)
    );

    always_comb begin
        n_state   = r_state;
        n_accum   = r_accum;
        n_num     = r_num;
        n_pend    = r_pend;
        n_phase   = r_phase;
        n_err     = r_err;
        n_ovalid  = r_ovalid;
        n_ovalue  = r_ovalue;
        n_ostatus = r_ostatus;
        alu_req.start = 1'b0;
        alu_req.op    = r_pend;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            T_IDLE: begin
                if (w_in_acc) begin
                    if (w_is_nul) begin
                        n_state = T_EMIT;
                        if (r_err == ST_OK) begin
                            if (r_phase == PH_START) begin
                                n_err = ST_SYNTAX;
                            end else if (r_phase == PH_NUMBER) begin
                                alu_req.start = 1'b1;
                                n_state       = T_CALC_END;
                            end
                        end
                    end else if (r_err == ST_OK) begin
                        if (w_is_digit) begin
                            // number * 10 + digit as two shifts and two adds.
                            if (r_phase == PH_NUMBER) begin
                                n_num = {r_num[VALUE_W-4:0], 3'b000}
                                      + {r_num[VALUE_W-2:0], 1'b0} + w_digit;
                            end else begin
                                n_num = w_digit;
                            end
                            n_phase = PH_NUMBER;
                        end else if (w_is_op && (r_phase == PH_NUMBER)) begin
                            // The unit samples the old pending operator here.
                            alu_req.start = 1'b1;
                            n_pend        = op_of_char(i_in_char_code);
                            n_phase       = PH_AFTER_OP;
                            n_state       = T_CALC;
                        end else begin
                            n_err = ST_SYNTAX;
                        end
                    end
                end
            end
            T_CALC, T_CALC_END: begin
                if (alu_rsp.done) begin
                    if (alu_rsp.div_zero) begin
                        n_err = ST_DIVZERO;
                    end else begin
                        n_accum = w_alu_result;
                    end
                    n_state = (r_state == T_CALC) ? T_IDLE : T_EMIT;
                end
            end
            T_EMIT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid  = 1'b1;
                    n_ovalue  = (r_err == ST_OK) ? r_accum : '0;
                    n_ostatus = r_err;
                    n_accum   = '0;
                    n_num     = '0;
                    n_pend    = OP_ADD;
                    n_phase   = PH_START;
                    n_err     = ST_OK;
                    n_state   = T_IDLE;
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_accum  <= '0;
            r_num    <= '0;
            r_pend   <= OP_ADD;
            r_phase  <= PH_START;
            r_err    <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_accum  <= n_accum;
            r_num    <= n_num;
            r_pend   <= n_pend;
            r_phase  <= n_phase;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
        r_ovalue  <= n_ovalue;
        r_ostatus <= n_ostatus;
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_value  = signed'(OUT_W'(r_ovalue));
    assign o_out_status = r_ostatus;

    // The sequencer never starts the unit while it is still busy.
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> alu_rsp.idle)
        else $error("top: arithmetic unit started while busy");

    // Taking input again implies the previous calculation has finished.
    a_ready_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> alu_rsp.idle)
        else $error("top: input ready while the arithmetic unit is busy");

    // An error result always carries a zero value.
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_status != ST_OK)) |-> (o_out_value == '0))
        else $error("top: nonzero value reported with an error status");

    // A NUL word always leads to a result cycle before more input is taken.
    a_nul_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_nul) |=> (r_state != T_IDLE))
        else $error("top: end of expression did not reach the result stage");

endmodule
